@@ design/tt_chisq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_chisq_pkg
// Shared constants for the trend chi-square core: field widths and the
// packing of the stream data words.
// ----------------------------------------------------------------------------
package tt_chisq_pkg;

    // Width of one count field on the input stream.
    localparam int FIELD_BITS  = 16;
    // Number of count fields in one table.
    localparam int NUM_FIELDS  = 6;
    // Width of the statistic and the number of quotient bits produced.
    localparam int STAT_BITS   = 34;
    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_W  = FIELD_BITS * NUM_FIELDS;
    localparam int OUT_TDATA_W = ((STAT_BITS + 7) / 8) * 8;

endpackage

@@ design/tt_chisq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_chisq_front
// First three pipeline stages: totals, the narrow products, then the
// variance term, the trend difference and the invalid flag.
// ----------------------------------------------------------------------------
module tt_chisq_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [tt_chisq_pkg::FIELD_BITS-1:0] i_u0,
    input  logic [tt_chisq_pkg::FIELD_BITS-1:0] i_u1,
    input  logic [tt_chisq_pkg::FIELD_BITS-1:0] i_u2,
    input  logic [tt_chisq_pkg::FIELD_BITS-1:0] i_c0,
    input  logic [tt_chisq_pkg::FIELD_BITS-1:0] i_c1,
    input  logic [tt_chisq_pkg::FIELD_BITS-1:0] i_c2,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2*COUNT_BITS+3:0]           o_d,
    output logic [2*COUNT_BITS+6:0]           o_var,
    output logic [2*COUNT_BITS+3:0]           o_uc,
    output logic [COUNT_BITS+2:0]             o_n,
    output logic                              o_inv
);
    import tt_chisq_pkg::*;

    localparam int C   = COUNT_BITS;
    localparam int UB  = (C < FIELD_BITS) ? C : FIELD_BITS;
    localparam int AW  = C + 2;
    localparam int NW  = C + 3;
    localparam int TW  = C + 1;
    localparam int WW  = C + 4;
    localparam int SW  = C + 3;
    localparam int PW  = 2 * C + 4;
    localparam int S2W = 2 * C + 6;
    localparam int VW  = 2 * C + 7;

    // Counts reduced to the active width.
    logic [C-1:0] w_u0, w_u1, w_u2, w_c0, w_c1, w_c2;
    assign w_u0 = C'(i_u0[UB-1:0]);
    assign w_u1 = C'(i_u1[UB-1:0]);
    assign w_u2 = C'(i_u2[UB-1:0]);
    assign w_c0 = C'(i_c0[UB-1:0]);
    assign w_c1 = C'(i_c1[UB-1:0]);
    assign w_c2 = C'(i_c2[UB-1:0]);

    // Stage handshake: a stage loads when it is empty or drains forward.
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // Stage 1: row and column totals and the weighted sums.
    logic [AW-1:0] r1_ctl, r1_cas, r1_a, r1_b;
    logic [NW-1:0] r1_n;
    logic [WW-1:0] r1_w;
    logic [SW-1:0] r1_s1;
    logic [AW-1:0] n_ctl, n_cas;
    logic [TW-1:0] n_t1, n_t2;

    always_comb begin
        n_ctl = AW'(w_u0) + AW'(w_u1) + AW'(w_u2);
        n_cas = AW'(w_c0) + AW'(w_c1) + AW'(w_c2);
        n_t1  = TW'(w_u1) + TW'(w_c1);
        n_t2  = TW'(w_u2) + TW'(w_c2);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_ctl <= n_ctl;
            r1_cas <= n_cas;
            r1_n   <= NW'(n_ctl) + NW'(n_cas);
            r1_w   <= WW'(n_t1) + (WW'(n_t2) << 2);
            r1_s1  <= SW'(n_t1) + (SW'(n_t2) << 1);
            r1_a   <= AW'(w_c1) + (AW'(w_c2) << 1);
            r1_b   <= AW'(w_u1) + (AW'(w_u2) << 1);
        end
    end

    // Stage 2: the narrow products.
    logic [VW-1:0]  r2_nw;
    logic [S2W-1:0] r2_s1sq;
    logic [PW-1:0]  r2_p, r2_q, r2_uc;
    logic [NW-1:0]  r2_n;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_nw   <= VW'(r1_n) * VW'(r1_w);
            r2_s1sq <= S2W'(r1_s1) * S2W'(r1_s1);
            r2_p    <= PW'(r1_ctl) * PW'(r1_a);
            r2_q    <= PW'(r1_cas) * PW'(r1_b);
            r2_uc   <= PW'(r1_ctl) * PW'(r1_cas);
            r2_n    <= r1_n;
        end
    end

    // Stage 3: variance term, absolute trend difference, invalid flag.
    logic [PW-1:0] r3_d, r3_uc;
    logic [VW-1:0] r3_var;
    logic [NW-1:0] r3_n;
    logic          r3_inv;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_var <= r2_nw - VW'(r2_s1sq);
            r3_d   <= (r2_p >= r2_q) ? (r2_p - r2_q) : (r2_q - r2_p);
            r3_uc  <= r2_uc;
            r3_n   <= r2_n;
            r3_inv <= (r2_uc == '0) || (r2_nw == VW'(r2_s1sq));
        end
    end

    assign o_valid = r_v3;
    assign o_d     = r3_d;
    assign o_var   = r3_var;
    assign o_uc    = r3_uc;
    assign o_n     = r3_n;
    assign o_inv   = r3_inv;

endmodule

@@ design/tt_chisq_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_chisq_mul
// Three pipeline stages that build the wide numerator and denominator:
// the square of the difference, split partial products, and their sums.
// ----------------------------------------------------------------------------
module tt_chisq_mul #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [2*COUNT_BITS+3:0]                i_d,
    input  logic [2*COUNT_BITS+6:0]                i_var,
    input  logic [2*COUNT_BITS+3:0]                i_uc,
    input  logic [COUNT_BITS+2:0]                  i_n,
    input  logic                                   i_inv,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [5*COUNT_BITS+10+FRAC_BITS:0]     o_num,
    output logic [4*COUNT_BITS+10:0]               o_den,
    output logic                                   o_inv
);
    import tt_chisq_pkg::*;

    localparam int C   = COUNT_BITS;
    localparam int PW  = 2 * C + 4;
    localparam int VW  = 2 * C + 7;
    localparam int NW  = C + 3;
    localparam int D2W = 2 * PW;
    localparam int H   = PW;
    localparam int LOW = H + NW;
    localparam int HIW = (D2W - H) + NW;
    localparam int MW  = 5 * C + 11;
    localparam int QW  = MW + FRAC_BITS;
    localparam int V   = C + 4;
    localparam int VLW = PW + V;
    localparam int VHW = PW + (VW - V);
    localparam int DW  = 4 * C + 11;

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // Stage 1: square of the trend difference.
    logic [D2W-1:0] r1_d2;
    logic [VW-1:0]  r1_var;
    logic [PW-1:0]  r1_uc;
    logic [NW-1:0]  r1_n;
    logic           r1_inv;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_d2  <= D2W'(i_d) * D2W'(i_d);
            r1_var <= i_var;
            r1_uc  <= i_uc;
            r1_n   <= i_n;
            r1_inv <= i_inv;
        end
    end

    // Stage 2: partial products, each operand pair split in two halves.
    logic [LOW-1:0] r2_nlo;
    logic [HIW-1:0] r2_nhi;
    logic [VLW-1:0] r2_dlo;
    logic [VHW-1:0] r2_dhi;
    logic           r2_inv;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_nlo <= LOW'(r1_d2[H-1:0]) * LOW'(r1_n);
            r2_nhi <= HIW'(r1_d2[D2W-1:H]) * HIW'(r1_n);
            r2_dlo <= VLW'(r1_uc) * VLW'(r1_var[V-1:0]);
            r2_dhi <= VHW'(r1_uc) * VHW'(r1_var[VW-1:V]);
            r2_inv <= r1_inv;
        end
    end

    // Stage 3: recombine the halves; the fraction scaling is a shift.
    logic [QW-1:0] r3_num;
    logic [DW-1:0] r3_den;
    logic          r3_inv;
    logic [MW-1:0] n_m;

    assign n_m = MW'(r2_nlo) + (MW'(r2_nhi) << H);

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_num <= QW'(n_m) << FRAC_BITS;
            r3_den <= DW'(r2_dlo) + (DW'(r2_dhi) << V);
            r3_inv <= r2_inv;
        end
    end

    assign o_valid = r_v3;
    assign o_num   = r3_num;
    assign o_den   = r3_den;
    assign o_inv   = r3_inv;

endmodule

@@ design/tt_chisq_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_chisq_div
// Pipelined restoring divider: one saturation check stage, one stage per
// quotient bit, and an output register that forms the final result.
// ----------------------------------------------------------------------------
module tt_chisq_div #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [5*COUNT_BITS+10+FRAC_BITS:0]     i_num,
    input  logic [4*COUNT_BITS+10:0]               i_den,
    input  logic                                   i_inv,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [tt_chisq_pkg::STAT_BITS-1:0]     o_stat,
    output logic                                   o_inv
);
    import tt_chisq_pkg::*;

    localparam int C  = COUNT_BITS;
    localparam int QW = 5 * C + 11 + FRAC_BITS;
    localparam int DW = 4 * C + 11;
    localparam int CW = (QW > DW + STAT_BITS) ? QW : DW + STAT_BITS;
    localparam int NS = STAT_BITS;

    // Stage 0 checks saturation, stages 1..NS each resolve one quotient bit.
    logic                r_v   [0:NS];
    logic [CW-1:0]       r_rem [0:NS];
    logic [CW-1:0]       r_den [0:NS];
    logic [NS-1:0]       r_q   [0:NS];
    logic                r_sat [0:NS];
    logic                r_inv [0:NS];
    logic                w_rdy [0:NS+1];
    logic                r_ov;
    logic [NS-1:0]       r_stat;
    logic                r_oinv;

    assign w_rdy[NS+1] = !r_ov || i_ready;
    assign o_ready     = w_rdy[0];

    genvar k;
    generate
        for (k = 0; k <= NS; k++) begin : g_rdy
            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    endgenerate

    // Saturation stage: the quotient overflows when num >= den * 2^NS.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= CW'(i_den);
            r_q[0]   <= '0;
            r_sat[0] <= CW'(i_num) >= (CW'(i_den) << NS);
            r_inv[0] <= i_inv;
        end
    end

    // Quotient bit stages, most significant bit first.
    generate
        for (k = 1; k <= NS; k++) begin : g_bit
            localparam int SH = NS - k;
            logic [CW-1:0] w_sub;
            logic          w_ge;
            assign w_sub = r_den[k-1] << SH;
            assign w_ge  = r_rem[k-1] >= w_sub;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k]) begin
                    r_rem[k] <= w_ge ? (r_rem[k-1] - w_sub) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                    r_q[k]   <= r_q[k-1] | (NS'(w_ge) << SH);
                    r_sat[k] <= r_sat[k-1];
                    r_inv[k] <= r_inv[k-1];
                end
            end
        end
    endgenerate

    // Output register: invalid forces zero, overflow forces the maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rdy[NS+1]) begin
            r_ov <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NS+1]) begin
            r_oinv <= r_inv[NS];
            if (r_inv[NS]) begin
                r_stat <= '0;
            end else if (r_sat[NS]) begin
                r_stat <= '1;
            end else begin
                r_stat <= r_q[NS];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_stat  = r_stat;
    assign o_inv   = r_oinv;

endmodule

@@ design/trend_test_chi_square_core.sv @@
`timescale 1ns / 1ps
// Pipeline: registered stages from input transfer to result (3 front, 3 multiply,
// 1 saturation check, 34 quotient-bit stages, 1 output register).
// Throughput: one table per cycle unless i_m_tready holds the pipeline; each stage
// holds its own valid bit and loads whenever it is empty or its successor moves on.
// Reset: synchronous active-low i_rst_n clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// trend_test_chi_square_core
// Cochran-Armitage trend chi-square on a 2x3 genotype table, computed as one
// exact fixed-point quotient with saturation and an invalid flag.
// ----------------------------------------------------------------------------
module trend_test_chi_square_core #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // control_hom_ref, control_het, control_hom_alt, case_hom_ref, case_het,
    // case_hom_alt, 16 bits each from the lowest bit up.
    input  logic [tt_chisq_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // statistic in bits 33:0, zero padding above.
    output logic [tt_chisq_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // invalid in bit 0.
    output logic                                   o_m_tuser
);
    import tt_chisq_pkg::*;

    localparam int C  = COUNT_BITS;
    localparam int QW = 5 * C + 11 + FRAC_BITS;
    localparam int DW = 4 * C + 11;

    logic              w_f_valid, w_f_ready;
    logic [2*C+3:0]    w_f_d, w_f_uc;
    logic [2*C+6:0]    w_f_var;
    logic [C+2:0]      w_f_n;
    logic              w_f_inv;
    logic              w_m_valid, w_m_ready;
    logic [QW-1:0]     w_m_num;
    logic [DW-1:0]     w_m_den;
    logic              w_m_inv;
    logic [STAT_BITS-1:0] w_stat;

    // Totals, narrow products and the variance term.
    tt_chisq_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_u0    (i_s_tdata[0*FIELD_BITS +: FIELD_BITS]),
        .i_u1    (i_s_tdata[1*FIELD_BITS +: FIELD_BITS]),
        .i_u2    (i_s_tdata[2*FIELD_BITS +: FIELD_BITS]),
        .i_c0    (i_s_tdata[3*FIELD_BITS +: FIELD_BITS]),
        .i_c1    (i_s_tdata[4*FIELD_BITS +: FIELD_BITS]),
        .i_c2    (i_s_tdata[5*FIELD_BITS +: FIELD_BITS]),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_d     (w_f_d),
        .o_var   (w_f_var),
        .o_uc    (w_f_uc),
        .o_n     (w_f_n),
        .o_inv   (w_f_inv)
    );

    // Wide numerator and denominator.
    tt_chisq_mul #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_d     (w_f_d),
        .i_var   (w_f_var),
        .i_uc    (w_f_uc),
        .i_n     (w_f_n),
        .i_inv   (w_f_inv),
        .o_valid (w_m_valid),
        .i_ready (w_m_ready),
        .o_num   (w_m_num),
        .o_den   (w_m_den),
        .o_inv   (w_m_inv)
    );

    // Pipelined division and result formatting.
    tt_chisq_div #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_valid),
        .o_ready (w_m_ready),
        .i_num   (w_m_num),
        .i_den   (w_m_den),
        .i_inv   (w_m_inv),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_stat  (w_stat),
        .o_inv   (o_m_tuser)
    );

    assign o_m_tdata = OUT_TDATA_W'(w_stat);

endmodule
